### design/keyword_identifier_lexer_macros.svh
// assertion macros for the lexer checker
`ifndef KEYWORD_IDENTIFIER_LEXER_MACROS_SVH
`define KEYWORD_IDENTIFIER_LEXER_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define KIL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lexer check failed");

// next-cycle implication, sampled on clk, off during reset
`define KIL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

### design/kil_pkg.sv
package kil_pkg;

    // token kinds and keyword numbers
    typedef enum logic [1:0] {
        TOK_SYMBOL  = 2'd0,
        TOK_KEYWORD = 2'd1,
        TOK_IDENT   = 2'd2
    } token_kind_t;

    typedef enum logic [1:0] {
        KW_WHERE  = 2'd0,
        KW_SELECT = 2'd1,
        KW_FROM   = 2'd2
    } kw_index_t;

    // identifier length saturation point
    localparam logic [7:0] LENGTH_LIMIT = 8'd255;
    localparam int QUEUE_DEPTH_DEF = 4;

    // special characters
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;

    // keyword spellings, zero padded
    localparam logic [7:0] KW_TEXT [3][6] = '{
        '{8'h77, 8'h68, 8'h65, 8'h72, 8'h65, 8'h00},
        '{8'h73, 8'h65, 8'h6C, 8'h65, 8'h63, 8'h74},
        '{8'h66, 8'h72, 8'h6F, 8'h6D, 8'h00, 8'h00}
    };
    localparam logic [7:0] KW_LEN [3] = '{8'd5, 8'd6, 8'd4};

    // one token word
    typedef struct packed {
        token_kind_t kind;
        kw_index_t   kw;
        logic [7:0]  sym;
        logic [7:0]  len;
        logic [15:0] line;
        logic [15:0] col;
    } token_t;

    // what one input character leaves in the queue: one or two tokens
    typedef struct packed {
        token_t tok0;
        token_t tok1;
        logic   two;
    } entry_t;

    function automatic logic [15:0] sat_inc16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // keywords in mask that still match with character c at position pos
    function automatic logic [2:0] kw_match(logic [2:0] mask, logic [7:0] pos,
                                            logic [7:0] c);
        logic [2:0] r;
        r = '0;
        for (int i = 0; i < 3; i++) begin
            if (mask[i] && (pos < KW_LEN[i]) && (KW_TEXT[i][pos[2:0]] == c))
                r[i] = 1'b1;
        end
        return r;
    endfunction

endpackage

### design/kil_front.sv
module kil_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [7:0]        char_code,
    input  logic              is_end,
    input  logic              q_full,
    output logic              q_push,
    output kil_pkg::entry_t   q_data
);

    logic [15:0] line_reg, line_next;
    logic [15:0] col_reg, col_next;
    logic        in_id_reg, in_id_next;
    logic [7:0]  id_len_reg, id_len_next;
    logic [15:0] id_start_reg, id_start_next;
    logic [2:0]  kw_poss_reg, kw_poss_next;

    logic           accept;
    logic           is_letter, is_digit, is_sym, is_nl, alnum;
    logic           extend, flush, sym_tok;
    kil_pkg::token_t id_word, sym_word;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // character classes
    always_comb
    begin
        is_letter = ((char_code >= 8'h61) && (char_code <= 8'h7A)) ||
                    ((char_code >= 8'h41) && (char_code <= 8'h5A));
        is_digit  = (char_code >= 8'h30) && (char_code <= 8'h39);
        is_sym    = (char_code == kil_pkg::CH_COMMA) || (char_code == kil_pkg::CH_QUOTE) ||
                    (char_code == kil_pkg::CH_EQUALS);
        is_nl     = (char_code == kil_pkg::CH_NEWLINE);
        alnum     = is_letter || is_digit;
        extend    = !is_end && in_id_reg && alnum;
        flush     = in_id_reg && (is_end || !alnum);
        sym_tok   = !is_end && is_sym;
    end

    // pending identifier as a token
    always_comb
    begin
        id_word      = '0;
        id_word.kind = kil_pkg::TOK_IDENT;
        id_word.kw   = kil_pkg::KW_WHERE;
        id_word.sym  = 8'd0;
        id_word.len  = id_len_reg;
        id_word.line = line_reg;
        id_word.col  = id_start_reg;
        priority if (kw_poss_reg[0] && (id_len_reg == kil_pkg::KW_LEN[0]))
        begin
            id_word.kind = kil_pkg::TOK_KEYWORD;
            id_word.kw   = kil_pkg::KW_WHERE;
        end
        else if (kw_poss_reg[1] && (id_len_reg == kil_pkg::KW_LEN[1]))
        begin
            id_word.kind = kil_pkg::TOK_KEYWORD;
            id_word.kw   = kil_pkg::KW_SELECT;
        end
        else if (kw_poss_reg[2] && (id_len_reg == kil_pkg::KW_LEN[2]))
        begin
            id_word.kind = kil_pkg::TOK_KEYWORD;
            id_word.kw   = kil_pkg::KW_FROM;
        end
        else
        begin
            id_word.kind = kil_pkg::TOK_IDENT;
        end
    end

    // symbol token at the current position
    always_comb
    begin
        sym_word      = '0;
        sym_word.kind = kil_pkg::TOK_SYMBOL;
        sym_word.kw   = kil_pkg::KW_WHERE;
        sym_word.sym  = char_code;
        sym_word.len  = 8'd1;
        sym_word.line = line_reg;
        sym_word.col  = col_reg;
    end

    // queue entry
    always_comb
    begin
        q_push      = accept && (flush || sym_tok);
        q_data.tok0 = flush ? id_word : sym_word;
        q_data.tok1 = sym_word;
        q_data.two  = flush && sym_tok;
    end

    // position and identifier tracking
    always_comb
    begin
        line_next     = line_reg;
        col_next      = col_reg;
        in_id_next    = in_id_reg;
        id_len_next   = id_len_reg;
        id_start_next = id_start_reg;
        kw_poss_next  = kw_poss_reg;
        if (flush)
        begin
            in_id_next   = 1'b0;
            id_len_next  = 8'd0;
            kw_poss_next = 3'd0;
        end
        if (!is_end)
        begin
            priority if (extend)
            begin
                kw_poss_next = kil_pkg::kw_match(kw_poss_reg, id_len_reg, char_code);
                if (id_len_reg < kil_pkg::LENGTH_LIMIT)
                    id_len_next = id_len_reg + 8'd1;
                col_next = kil_pkg::sat_inc16(col_reg);
            end
            else if (is_letter)
            begin
                in_id_next    = 1'b1;
                id_len_next   = 8'd1;
                id_start_next = col_reg;
                kw_poss_next  = kil_pkg::kw_match(3'b111, 8'd0, char_code);
                col_next      = kil_pkg::sat_inc16(col_reg);
            end
            else if (is_nl)
            begin
                line_next = kil_pkg::sat_inc16(line_reg);
                col_next  = 16'd1;
            end
            else
            begin
                col_next = kil_pkg::sat_inc16(col_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_reg     <= 16'd1;
            col_reg      <= 16'd1;
            in_id_reg    <= 1'b0;
            id_len_reg   <= 8'd0;
            id_start_reg <= 16'd0;
            kw_poss_reg  <= 3'd0;
        end
        else if (accept)
        begin
            line_reg     <= line_next;
            col_reg      <= col_next;
            in_id_reg    <= in_id_next;
            id_len_reg   <= id_len_next;
            id_start_reg <= id_start_next;
            kw_poss_reg  <= kw_poss_next;
        end
    end

endmodule

### design/kil_queue.sv
module kil_queue #(
    parameter int DEPTH = kil_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  kil_pkg::entry_t  push_data,
    output logic             full,
    input  logic             pop,
    output kil_pkg::entry_t  pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    kil_pkg::entry_t mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
            if (do_push && !do_pop)
                count_reg <= count_reg + CW'(1);
            else if (do_pop && !do_push)
                count_reg <= count_reg - CW'(1);
        end
    end

endmodule

### design/kil_back.sv
module kil_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  kil_pkg::entry_t  q_data,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output kil_pkg::token_t  out_tok,
    output logic             out_last
);

    logic            valid_reg;
    logic            pend_reg;
    logic            last_reg;
    kil_pkg::token_t tok_reg;
    kil_pkg::token_t hold_reg;
    logic            load_ok;

    assign load_ok   = !valid_reg || out_ready;
    assign q_pop     = load_ok && !pend_reg && !q_empty;
    assign out_valid = valid_reg;
    assign out_tok   = tok_reg;
    assign out_last  = last_reg;

    // control: output valid and held second word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else if (load_ok)
        begin
            if (pend_reg)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= 1'b0;
            end
            else if (!q_empty)
            begin
                valid_reg <= 1'b1;
                pend_reg  <= q_data.two;
            end
            else
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // payload: output word and skid for the second token
    always_ff @(posedge clk)
    begin
        if (load_ok)
        begin
            if (pend_reg)
            begin
                tok_reg  <= hold_reg;
                last_reg <= 1'b1;
            end
            else if (!q_empty)
            begin
                tok_reg  <= q_data.tok0;
                last_reg <= !q_data.two;
                hold_reg <= q_data.tok1;
            end
        end
    end

endmodule

### design/keyword_identifier_lexer.sv
// Keyword and identifier lexer.
// Input channel: in_valid/in_ready with char_code and is_end, one character
// or end marker per word. Output channel: out_valid/out_ready with one token
// per word (kind, keyword number, symbol, length, start line and column) and
// last_of_run set on the last token caused by one input word.
// Throughput: one input word per cycle while the queue has room. A character
// that closes an identifier and is itself a symbol yields two tokens, which
// leave as two output words. A token is written into the queue at the edge
// that takes the word, then moves into the output register once that is free.
// The front tracks line, column and the open identifier and writes tokens
// into a QUEUE_DEPTH entry queue; the back drains it through an output
// register with a one-word skid for the second token.
// When the receiver stalls, the output word holds, the queue fills, and
// in_ready drops once the queue is full; input stalls do not disturb output.
// Reset puts line and column at 1, clears any open identifier and empties
// the queue and output.
module keyword_identifier_lexer #(
    parameter int QUEUE_DEPTH = kil_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  char_code,
    input  logic        is_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  token_kind,
    output logic [1:0]  keyword_index,
    output logic [7:0]  symbol_code,
    output logic [7:0]  token_length,
    output logic [15:0] token_line,
    output logic [15:0] token_column,
    output logic        last_of_run
);

    logic            q_full, q_empty, q_push, q_pop;
    kil_pkg::entry_t q_wdata, q_rdata;
    kil_pkg::token_t out_tok;

    // front: classify characters and build tokens
    kil_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_code (char_code),
        .is_end    (is_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_wdata)
    );

    // token queue between front and back
    kil_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    // back: deliver tokens one word at a time
    kil_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .q_data    (q_rdata),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_tok   (out_tok),
        .out_last  (last_of_run)
    );

    assign token_kind    = 2'(out_tok.kind);
    assign keyword_index = 2'(out_tok.kw);
    assign symbol_code   = out_tok.sym;
    assign token_length  = out_tok.len;
    assign token_line    = out_tok.line;
    assign token_column  = out_tok.col;

endmodule

### design/kil_checker.sv
`include "keyword_identifier_lexer_macros.svh"

module kil_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  token_kind,
    input logic [1:0]  keyword_index,
    input logic [7:0]  symbol_code,
    input logic [7:0]  token_length,
    input logic [15:0] token_line,
    input logic [15:0] token_column,
    input logic        last_of_run
);

    // stalled output word holds
    `KIL_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(token_length) && $stable(token_column) && $stable(last_of_run))

    // symbol tokens are one character long and carry no keyword number
    `KIL_ASSERT_NOW(a_sym_shape, out_valid && (token_kind == 2'(kil_pkg::TOK_SYMBOL)), (token_length == 8'd1) && (keyword_index == 2'(kil_pkg::KW_WHERE)))

    // word tokens carry no symbol and a real start position
    `KIL_ASSERT_NOW(a_word_pos, out_valid && (token_kind != 2'(kil_pkg::TOK_SYMBOL)), (symbol_code == 8'd0) && (token_line != 16'd0) && (token_column != 16'd0))

    // keyword lengths are those of the keywords themselves
    `KIL_ASSERT_NOW(a_kw_len, out_valid && (token_kind == 2'(kil_pkg::TOK_KEYWORD)), (token_length >= 8'd4) && (token_length <= 8'd6))

    // an identifier has no keyword number and a nonzero length
    `KIL_ASSERT_NOW(a_id_kw, out_valid && (token_kind == 2'(kil_pkg::TOK_IDENT)), (keyword_index == 2'(kil_pkg::KW_WHERE)) && (token_length != 8'd0))

endmodule

bind keyword_identifier_lexer kil_checker u_kil_checker (.*);

### bench/keyword_identifier_lexer_tb.sv
// one token word as seen on the output port
typedef struct packed {
    kil_pkg::token_kind_t kind;
    kil_pkg::kw_index_t   kw;
    logic [7:0]  sym;
    logic [7:0]  len;
    logic [15:0] line;
    logic [15:0] col;
    logic        last;
} lex_token_t;

// spelling of keyword k
function automatic string kw_word(int k);
    case (k)
        int'(kil_pkg::KW_WHERE): return "where";
        int'(kil_pkg::KW_SELECT): return "select";
        default: return "from";
    endcase
endfunction

// tracks line, column and the open identifier; holds the tokens still owed
class lexer_scoreboard;
    lex_token_t  tokens_due[$];
    lex_token_t  run[$];
    int          error_count;
    logic [15:0] cur_line;
    logic [15:0] cur_col;
    bit          in_word;
    logic [7:0]  word_len;
    logic [15:0] word_col;
    bit [2:0]    kw_live;

    function new();
        cur_line    = 16'd1;
        cur_col     = 16'd1;
        in_word     = 1'b0;
        word_len    = 8'd0;
        word_col    = 16'd0;
        kw_live     = 3'b000;
        error_count = 0;
    endfunction

    function bit is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function bit is_num(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function logic [15:0] bump16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    // keyword k has character c at position pos
    function bit kw_char_fits(int k, int pos, logic [7:0] c);
        string w;
        w = kw_word(k);
        return (pos < w.len()) && (w[pos] == c);
    endfunction

    // emit the open identifier as keyword or identifier token
    function void close_word();
        lex_token_t t;
        t.kind = kil_pkg::TOK_IDENT;
        t.kw   = kil_pkg::KW_WHERE;
        for (int k = 0; k < 3; k++)
        begin
            if (kw_live[k] && word_len == kw_word(k).len() && t.kind == kil_pkg::TOK_IDENT)
            begin
                t.kind = kil_pkg::TOK_KEYWORD;
                t.kw   = kil_pkg::kw_index_t'(k);
            end
        end
        t.sym  = 8'd0;
        t.len  = word_len;
        t.line = cur_line;
        t.col  = word_col;
        t.last = 1'b0;
        run.push_back(t);
        in_word  = 1'b0;
        word_len = 8'd0;
        kw_live  = 3'b000;
    endfunction

    // accepted input word: advance the state and queue the tokens it causes
    function void take_char(logic [7:0] c, logic e);
        lex_token_t t;
        run.delete();
        if (e)
        begin
            if (in_word)
                close_word();
        end
        else if (in_word && (is_alpha(c) || is_num(c)))
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (!kw_char_fits(k, word_len, c))
                    kw_live[k] = 1'b0;
            end
            if (word_len < kil_pkg::LENGTH_LIMIT)
                word_len = word_len + 8'd1;
            cur_col = bump16(cur_col);
        end
        else
        begin
            if (in_word)
                close_word();
            if (is_alpha(c))
            begin
                in_word  = 1'b1;
                word_len = 8'd1;
                word_col = cur_col;
                for (int k = 0; k < 3; k++)
                    kw_live[k] = kw_char_fits(k, 0, c);
                cur_col = bump16(cur_col);
            end
            else if (c == kil_pkg::CH_COMMA || c == kil_pkg::CH_QUOTE ||
                     c == kil_pkg::CH_EQUALS)
            begin
                t.kind = kil_pkg::TOK_SYMBOL;
                t.kw   = kil_pkg::KW_WHERE;
                t.sym  = c;
                t.len  = 8'd1;
                t.line = cur_line;
                t.col  = cur_col;
                t.last = 1'b0;
                run.push_back(t);
                cur_col = bump16(cur_col);
            end
            else if (c == kil_pkg::CH_NEWLINE)
            begin
                cur_line = bump16(cur_line);
                cur_col  = 16'd1;
            end
            else
                cur_col = bump16(cur_col);
        end
        if (run.size() > 0)
            run[run.size() - 1].last = 1'b1;
        foreach (run[i])
            tokens_due.push_back(run[i]);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            error_count++;
            $display("%0t: %s expected %0d, actual %0d", $time, field, want, got);
        end
    endfunction

    // accepted output word against the oldest token owed
    function void check_token(lex_token_t got);
        lex_token_t want;
        if (tokens_due.size() == 0)
        begin
            error_count++;
            $display("%0t: token expected none, actual kind %0d line %0d column %0d",
                     $time, got.kind, got.line, got.col);
            return;
        end
        want = tokens_due.pop_front();
        compare_field("token_kind", want.kind, got.kind);
        compare_field("keyword_index", want.kw, got.kw);
        compare_field("symbol_code", want.sym, got.sym);
        compare_field("token_length", want.len, got.len);
        compare_field("token_line", want.line, got.line);
        compare_field("token_column", want.col, got.col);
        compare_field("last_of_run", want.last, got.last);
    endfunction

    function int pending();
        return tokens_due.size();
    endfunction
endclass

module keyword_identifier_lexer_tb;
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  char_code = 8'd0;
    logic        is_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  token_kind;
    logic [1:0]  keyword_index;
    logic [7:0]  symbol_code;
    logic [7:0]  token_length;
    logic [15:0] token_line;
    logic [15:0] token_column;
    logic        last_of_run;

    lexer_scoreboard lex_sb;
    bit idle_on;
    int rx_hold;
    int words_sent;

    keyword_identifier_lexer DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .char_code    (char_code),
        .is_end       (is_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .keyword_index(keyword_index),
        .symbol_code  (symbol_code),
        .token_length (token_length),
        .token_line   (token_line),
        .token_column (token_column),
        .last_of_run  (last_of_run)
    );

    always #5 clk = ~clk;

    function automatic int draw_gap();
        return idle_on ? $urandom_range(0, 11) : 0;
    endfunction

    function automatic logic [7:0] rand_letter();
        int v;
        v = $urandom_range(0, 51);
        return (v < 26) ? 8'(8'h61 + v) : 8'(8'h41 + v - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int v;
        v = $urandom_range(0, 61);
        return (v < 10) ? 8'(8'h30 + v) : rand_letter();
    endfunction

    // offer one word, wait for the handshake, then maybe idle;
    // valid stays high on return only when no gap was drawn
    task automatic put_word(input logic [7:0] c, input logic e);
        int gap;
        in_valid  <= 1'b1;
        char_code <= c;
        is_end    <= e;
        @(posedge clk);
        while (in_ready !== 1'b1)
            @(posedge clk);
        lex_sb.take_char(c, e);
        words_sent++;
        @(negedge clk);
        gap = draw_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put_word(s[i], 1'b0);
    endtask

    task automatic send_ident(input int n);
        put_word(rand_letter(), 1'b0);
        repeat (n - 1) put_word(rand_alnum(), 1'b0);
    endtask

    // keyword exact, with one case flip, cut short, or run on
    task automatic send_keyword(input int k, input int mode);
        string w;
        int flip;
        int cut;
        w    = kw_word(k);
        flip = (mode == 1) ? $urandom_range(0, w.len() - 1) : -1;
        cut  = (mode == 2) ? 1 : 0;
        for (int i = 0; i < w.len() - cut; i++)
            put_word((i == flip) ? (w[i] ^ 8'h20) : w[i], 1'b0);
        if (mode == 3)
            put_word(rand_alnum(), 1'b0);
    endtask

    task automatic send_separator();
        case ($urandom_range(0, 9))
            0: put_word(8'h20, 1'b0);
            1: put_word(kil_pkg::CH_COMMA, 1'b0);
            2: put_word(kil_pkg::CH_QUOTE, 1'b0);
            3: put_word(kil_pkg::CH_EQUALS, 1'b0);
            4: put_word(kil_pkg::CH_NEWLINE, 1'b0);
            5: put_word(8'($urandom_range(0, 255)), 1'b1);
            6: put_word(8'h09, 1'b0);
            default: put_word(8'($urandom_range(0, 255)), 1'b0);
        endcase
    endtask

    // drop valid and hold until every owed token has left
    task automatic idle_until_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (lex_sb.pending() != 0)
            @(negedge clk);
    endtask

    // token sink with random backpressure and requested long holds
    initial
    begin : token_sink
        int gap;
        lex_token_t got;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                gap = rx_hold;
                rx_hold = 0;
            end
            else
                gap = draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (out_valid !== 1'b1)
                @(posedge clk);
            got.kind = kil_pkg::token_kind_t'(token_kind);
            got.kw   = kil_pkg::kw_index_t'(keyword_index);
            got.sym  = symbol_code;
            got.len  = token_length;
            got.line = token_line;
            got.col  = token_column;
            got.last = last_of_run;
            lex_sb.check_token(got);
            @(negedge clk);
        end
    end

    // run limit
    initial
    begin
        #10_000_000;
        $display("Mismatches found");
        $finish;
    end

    // stimulus
    initial
    begin : stimulus
        int limit;
        int next_switch;
        int pick;
        lex_sb = new();
        idle_on = 1'b1;
        rx_hold = 0;
        words_sent = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: keywords closed by symbols and by end, end with no word open
        send_text("where,select=from");
        put_word(kil_pkg::CH_COMMA, 1'b1);
        put_word(kil_pkg::CH_QUOTE, 1'b0);
        put_word(kil_pkg::CH_NEWLINE, 1'b0);
        put_word(8'hFF, 1'b0);
        send_text("Z9'");
        put_word(8'h80, 1'b1);
        idle_until_drained();

        // sink holds for a long stretch while words keep coming
        rx_hold = 80;
        idle_on = 1'b0;
        repeat (20) send_text("ab,");
        idle_until_drained();
        idle_on = 1'b1;

        // identifier length saturation
        send_ident(300);
        put_word(8'h20, 1'b0);
        send_ident(255);
        put_word(kil_pkg::CH_COMMA, 1'b0);
        send_ident(256);
        put_word(8'h00, 1'b1);

        // random sequences, mostly words with separators
        limit = 1550;
        next_switch = words_sent + 100;
        while (words_sent < limit)
        begin
            if (words_sent >= next_switch)
            begin
                idle_on = !idle_on;
                next_switch = words_sent + $urandom_range(40, 200);
            end
            pick = $urandom_range(0, 99);
            if (pick < 30)
                send_keyword($urandom_range(0, 2),
                             ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
            else if (pick < 60)
                send_ident($urandom_range(1, 12));
            else if (pick < 62)
                idle_until_drained();
            else if (pick < 82)
                repeat ($urandom_range(1, 4))
                    put_word(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0);
            send_separator();
        end

        idle_until_drained();
        repeat (20) @(posedge clk);
        if (lex_sb.error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule

### sim.f
+incdir+design
design/kil_pkg.sv
design/kil_front.sv
design/kil_queue.sv
design/kil_back.sv
design/keyword_identifier_lexer.sv
design/kil_checker.sv
bench/keyword_identifier_lexer_tb.sv
